### sv/frot_pkg.sv
// Shared types, codes and defaults for the frame quarter-turn rotator.
`timescale 1ns / 1ps

package frot_pkg;

  // Default frame store geometry
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Pixel word: red 23..16, green 15..8, blue 7..0
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_W      = 9;
  localparam int TURN_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 2'd2;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT  = 9'd256;
  localparam logic [TURN_W-1:0] RST_QUARTER_TURNS = 2'd1;

  // Quarter-turn codes
  localparam logic [TURN_W-1:0] TURN_0 = 2'd0;
  localparam logic [TURN_W-1:0] TURN_1 = 2'd1;
  localparam logic [TURN_W-1:0] TURN_2 = 2'd2;
  localparam logic [TURN_W-1:0] TURN_3 = 2'd3;

  // Input word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [TURN_W-1:0] quarter_turns;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic emitting;
    logic wr_en;
    logic last;
  } stat_t;

endpackage

### sv/frot_frame_mem.sv
// Frame store: single-port write, registered read.
`timescale 1ns / 1ps

module frot_frame_mem #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [frot_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [frot_pkg::PIX_W-1:0] rd_data
);
  import frot_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/frot_seq.sv
// Load counter, turned-frame position and source address generation.
`timescale 1ns / 1ps

module frot_seq #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  frot_pkg::cfg_t  cfg,
  input  frot_pkg::cmd_t  cmd,
  output frot_pkg::stat_t st,
  output logic [AW-1:0]   wr_addr,
  output logic [AW-1:0]   rd_addr
);
  import frot_pkg::*;

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW   = $clog2(MAXD + 1);
  localparam int PW   = $clog2(MAXD);
  localparam int SRW  = $clog2(MAX_HEIGHT);
  localparam int SCW  = $clog2(MAX_WIDTH);

  logic [CNTW-1:0]  load_count;
  logic [PW-1:0]    emit_row;
  logic [PW-1:0]    emit_col;
  logic             emitting;
  logic             last;
  logic [SRW-1:0]   src_row;
  logic [SCW-1:0]   src_col;
  logic [AW-1:0]    addr;

  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [WW+HW-1:0] prod;
  logic [CNTW-1:0]  total;
  logic [CNTW-1:0]  cnt_inc;
  logic [DW-1:0]    wd, hd, ow, oh, row_x, col_x, r, c, sr, sc;
  logic             col_end, row_end;
  logic [AW:0]      addr_sum;

  // Clamp dimensions into 1..MAX
  always_comb begin
    if (cfg.frame_width == '0) begin
      w = WW'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h = HW'(1);
    end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg.frame_height);
    end
  end

  assign prod    = (WW+HW)'(w) * (WW+HW)'(h);
  assign total   = CNTW'(prod);
  assign cnt_inc = load_count + CNTW'(1);

  assign wd    = DW'(w);
  assign hd    = DW'(h);
  assign ow    = cfg.quarter_turns[0] ? hd : wd;
  assign oh    = cfg.quarter_turns[0] ? wd : hd;
  assign row_x = DW'(emit_row);
  assign col_x = DW'(emit_col);
  assign r     = (row_x > oh - DW'(1)) ? oh - DW'(1) : row_x;
  assign c     = (col_x > ow - DW'(1)) ? ow - DW'(1) : col_x;

  assign col_end = col_x >= ow - DW'(1);
  assign row_end = row_x >= oh - DW'(1);

  // Turned position to source row and column
  always_comb begin
    case (cfg.quarter_turns)
      TURN_0: begin
        sr = r;
        sc = c;
      end
      TURN_1: begin
        sr = hd - DW'(1) - c;
        sc = r;
      end
      TURN_2: begin
        sr = hd - DW'(1) - r;
        sc = wd - DW'(1) - c;
      end
      default: begin
        sr = c;
        sc = wd - DW'(1) - r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
      emitting   <= 1'b0;
    end else if (cmd.load) begin
      load_count <= cnt_inc;
      if (cnt_inc >= total) begin
        emitting <= 1'b1;
        emit_row <= '0;
        emit_col <= '0;
      end
    end else if (cmd.emit) begin
      if (col_end) begin
        if (row_end) begin
          emitting   <= 1'b0;
          load_count <= '0;
          emit_row   <= '0;
          emit_col   <= '0;
        end else begin
          emit_col <= '0;
          emit_row <= emit_row + PW'(1);
        end
      end else begin
        emit_col <= emit_col + PW'(1);
      end
    end
  end

  // Coordinate stage, then address stage
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      src_row <= SRW'(sr);
      src_col <= SCW'(sc);
      last    <= col_end && row_end;
    end
  end

  assign addr_sum = (AW+1)'(src_row) * (AW+1)'(w) + (AW+1)'(src_col);

  always_ff @(posedge clk) begin
    addr <= addr_sum[AW-1:0];
  end

  assign st.emitting = emitting;
  assign st.wr_en    = cmd.load && (load_count < total);
  assign st.last     = last;
  assign wr_addr     = load_count[AW-1:0];
  assign rd_addr     = addr;

endmodule

### sv/frame_quarter_turn_rotator_unit.sv
// Top level of the frame quarter-turn rotator: handshake, config and output word.
`timescale 1ns / 1ps

// The block loads one RGB frame in raster order into an on-chip frame store
// (MAX_WIDTH x MAX_HEIGHT words of 24 bits), then answers each emit word with
// one pixel of the frame turned clockwise by quarter_turns quarter turns, in
// raster order of the turned frame; for odd turns the turned frame is
// frame_height wide and frame_width high. The final pixel carries last_pixel
// and the block goes back to loading. A word of the wrong kind for the phase
// is taken and dropped. A frame streams in at one pixel per clock. An emit
// word passes four steps: the map of the turned position to a source row and
// column, the row times width multiply into the store address, the store
// read, and the hand-off of the pixel to the output register, which waits
// while that register holds a stalled pixel; no new word is taken while an
// emit word is in these steps. The output register parts the two sides, so the
// next word is taken while a pixel still waits on out_stall. The frame store has no reset.
// Write configuration only between frames while idle.

module frame_quarter_turn_rotator_unit #(
  parameter int MAX_WIDTH  = frot_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = frot_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [frot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frot_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [frot_pkg::CH_W-1:0]       in_red,
  input  logic [frot_pkg::CH_W-1:0]       in_green,
  input  logic [frot_pkg::CH_W-1:0]       in_blue,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [frot_pkg::CH_W-1:0]       out_red,
  output logic [frot_pkg::CH_W-1:0]       out_green,
  output logic [frot_pkg::CH_W-1:0]       out_blue,
  output logic                            last_pixel
);
  import frot_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  cfg_t             cfg;
  cmd_t             cmd;
  stat_t            st;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_data;
  logic             in_take;
  logic             out_take;
  logic             out_load;

  // Configuration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= RST_FRAME_WIDTH;
      cfg.frame_height  <= RST_FRAME_HEIGHT;
      cfg.quarter_turns <= RST_QUARTER_TURNS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[DIM_W-1:0];
        CFG_QUARTER_TURNS: cfg.quarter_turns <= cfg_data[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a word only when no emit is in flight
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Wrong-kind words are taken but issue no command
  assign cmd.load = in_take && !st.emitting && (kind == KIND_LOAD);
  assign cmd.emit = in_take && st.emitting && (kind == KIND_EMIT);

  // Move the read pixel out once the output register is free or draining
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.emit) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_READ;
      ST_READ: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new pixel wins over the one draining in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word payload; no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red    <= rd_data[3*CH_W-1:2*CH_W];
      out_green  <= rd_data[2*CH_W-1:CH_W];
      out_blue   <= rd_data[CH_W-1:0];
      last_pixel <= st.last;
    end
  end

  frot_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .st      (st),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  frot_frame_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_mem (
    .clk     (clk),
    .wr_en   (st.wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (state == ST_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for the frame quarter-turn rotator unit.
`timescale 1ns / 1ps

// Frames are built as a plan of steps: configuration writes, pixel words,
// phase-wrong words that the block must drop, and drain points. A clocked
// driver walks the plan. It writes configuration only while the block is idle
// and drives one word at a time over valid/stall. Every accepted word goes
// through a local rotation tracker that keeps its own frame memory. Each
// emit word it serves queues one expected turned pixel. A clocked monitor
// stalls the output at random and checks every accepted pixel, field by
// field, against the oldest queued pixel.
module tb;
  import frot_pkg::*;

  localparam int          MAX_W         = DEF_MAX_WIDTH;
  localparam int          MAX_H         = DEF_MAX_HEIGHT;
  localparam int          TB_AW         = $clog2(MAX_W * MAX_H);
  localparam int          SETTLE_CYCLES = 12;       // deeper than the emit path
  localparam int          TARGET_WORDS  = 1200;
  localparam longint      LIMIT_NS      = 10_000_000;

  typedef enum logic [1:0] {
    OP_WORD,
    OP_CFG,
    OP_DRAIN
  } feed_op_t;

  typedef struct packed {
    feed_op_t                op;
    logic                    kind;
    logic [PIX_W-1:0]        pix;
    int unsigned             gap;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   data;
  } feed_step_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } turned_px_t;

  // DUT-facing signals; the driven ones are known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  kind      = KIND_LOAD;
  logic [CH_W-1:0]       in_red    = '0;
  logic [CH_W-1:0]       in_green  = '0;
  logic [CH_W-1:0]       in_blue   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  last_pixel;

  // Plan of steps and the pixels the rotation tracker expects
  feed_step_t  feed_plan[$];
  turned_px_t  turned_px_q[$];

  // Rotation tracker state
  logic [PIX_W-1:0]  frame_mem [0:MAX_W*MAX_H-1];
  logic [DIM_W-1:0]  cfg_w     = RST_FRAME_WIDTH;
  logic [DIM_W-1:0]  cfg_h     = RST_FRAME_HEIGHT;
  logic [TURN_W-1:0] cfg_turns = RST_QUARTER_TURNS;
  int unsigned       loaded_px = 0;
  int unsigned       out_row   = 0;
  int unsigned       out_col   = 0;
  bit                emit_phase = 1'b0;

  // Bookkeeping
  int unsigned errors        = 0;
  int unsigned words_taken   = 0;
  int unsigned words_dropped = 0;
  int unsigned pixels_seen   = 0;
  int unsigned plan_words    = 0;
  int unsigned turn_frames [4];
  bit          feed_done     = 1'b0;

  frame_quarter_turn_rotator_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .last_pixel (last_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // A zero dimension acts as one; anything past the store size is clipped.
  function automatic int unsigned eff_dim(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // Follow one accepted word: store a loaded pixel, or work out the turned
  // pixel that an emit word gets. Words of the wrong kind for the phase drop.
  task automatic predict_rotation(logic k, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                  logic [CH_W-1:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned ow;
    int unsigned oh;
    int unsigned rr;
    int unsigned cc;
    int unsigned sr;
    int unsigned sc;
    turned_px_t  px;
    w = eff_dim(32'(cfg_w), MAX_W);
    h = eff_dim(32'(cfg_h), MAX_H);
    words_taken++;
    if (!emit_phase) begin
      if (k != KIND_LOAD) begin
        words_dropped++;
        return;
      end
      if (loaded_px < w * h) frame_mem[TB_AW'(loaded_px)] = {r, g, b};
      loaded_px++;
      if (loaded_px >= w * h) begin
        emit_phase = 1'b1;
        out_row = 0;
        out_col = 0;
      end
    end else if (k != KIND_EMIT) begin
      words_dropped++;
    end else begin
      ow = cfg_turns[0] ? h : w;
      oh = cfg_turns[0] ? w : h;
      rr = (out_row < oh - 1) ? out_row : oh - 1;
      cc = (out_col < ow - 1) ? out_col : ow - 1;
      case (cfg_turns)
        TURN_0: begin
          sr = rr;
          sc = cc;
        end
        TURN_1: begin
          sr = h - 1 - cc;
          sc = rr;
        end
        TURN_2: begin
          sr = h - 1 - rr;
          sc = w - 1 - cc;
        end
        default: begin
          sr = cc;
          sc = w - 1 - rr;
        end
      endcase
      {px.red, px.green, px.blue} = frame_mem[TB_AW'(sr * w + sc)];
      px.last = 1'b0;
      if (out_col >= ow - 1) begin
        if (out_row >= oh - 1) begin
          px.last = 1'b1;
        end else begin
          out_col = 0;
          out_row++;
        end
      end else begin
        out_col++;
      end
      turned_px_q.push_back(px);
      if (px.last) begin
        emit_phase = 1'b0;
        loaded_px  = 0;
        out_row    = 0;
        out_col    = 0;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------
  task automatic add_word(logic k, logic [PIX_W-1:0] pix, bit calm);
    feed_step_t  st;
    int unsigned pick;
    st      = '0;
    st.op   = OP_WORD;
    st.kind = k;
    st.pix  = pix;
    pick    = $urandom_range(0, 99);
    // mostly back to back, some short gaps, a few long ones
    if (calm || pick < 65) st.gap = 0;
    else if (pick < 93)    st.gap = $urandom_range(1, 3);
    else                   st.gap = $urandom_range(8, 40);
    feed_plan.push_back(st);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    feed_step_t st;
    st       = '0;
    st.op    = OP_CFG;
    st.index = idx;
    st.data  = value[CFG_DATA_W-1:0];
    feed_plan.push_back(st);
  endtask

  task automatic add_drain();
    feed_step_t st;
    st    = '0;
    st.op = OP_DRAIN;
    feed_plan.push_back(st);
  endtask

  // One frame: settle, set geometry and turns, load every pixel, then ask for
  // every turned pixel. Phase-wrong words are sprinkled in at noise_pct.
  task automatic add_frame(int unsigned w_reg, int unsigned h_reg, logic [TURN_W-1:0] turns,
                           bit calm, bit stark, int unsigned noise_pct);
    int unsigned      n;
    int unsigned      pause_at;
    logic [PIX_W-1:0] pix;
    add_drain();
    add_cfg(CFG_FRAME_WIDTH, w_reg);
    add_cfg(CFG_FRAME_HEIGHT, h_reg);
    add_cfg(CFG_QUARTER_TURNS, 32'(turns));
    n = eff_dim(w_reg, MAX_W) * eff_dim(h_reg, MAX_H);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) add_word(KIND_EMIT, PIX_W'($urandom), calm);
      if (stark) pix = i[0] ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
      else       pix = PIX_W'($urandom);
      add_word(KIND_LOAD, pix, calm);
      plan_words++;
    end
    // now and then hold the sender mid-frame until every pixel is back
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) add_drain();
      if ($urandom_range(0, 99) < noise_pct) add_word(KIND_LOAD, PIX_W'($urandom), calm);
      add_word(KIND_EMIT, PIX_W'($urandom), calm);
      plan_words++;
    end
    turn_frames[turns]++;
  endtask

  function automatic int unsigned pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)  return 0;
    if (pick < 88) return $urandom_range(1, 6);
    return $urandom_range(7, 16);
  endfunction

  initial begin : build_plan
    bit big_done;
    big_done = 1'b0;
    foreach (turn_frames[i]) turn_frames[i] = 0;

    // Directed: single pixel, every turn, zero dimensions, solid black and
    // white pixels, and dropped words in both phases.
    add_frame(1, 1, TURN_0, 1'b1, 1'b1, 50);
    add_frame(2, 3, TURN_1, 1'b0, 1'b0, 30);
    add_frame(0, 0, TURN_2, 1'b1, 1'b0, 0);
    add_frame(2, 2, TURN_3, 1'b0, 1'b1, 20);

    // Random frames, mostly small; the store extremes, clipped and zero
    // dimensions among them, come in once early on.
    while (plan_words < TARGET_WORDS) begin
      add_frame(pick_dim(), pick_dim(), TURN_W'($urandom_range(0, 3)),
                $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0,
                $urandom_range(0, 15));
      if (!big_done && plan_words > TARGET_WORDS / 8) begin
        add_frame(511, 1, TURN_2, 1'b0, 1'b0, 5);
        add_frame(0, 400, TURN_3, 1'b1, 1'b0, 0);
        big_done = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: one NBA per signal per edge; hold a stalled word untouched.
  // ---------------------------------------------------------------------
  int unsigned gap_left = 0;
  bit          draining = 1'b0;

  always @(posedge clk) begin : feed_driver
    feed_step_t st;
    logic       v_nxt;
    logic       wr_nxt;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:   cfg_w     = cfg_data[DIM_W-1:0];
          CFG_FRAME_HEIGHT:  cfg_h     = cfg_data[DIM_W-1:0];
          CFG_QUARTER_TURNS: cfg_turns = cfg_data[TURN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_rotation(kind, in_red, in_green, in_blue);

      v_nxt  = in_valid && in_stall;   // hold the word while stalled
      wr_nxt = 1'b0;
      if (!v_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (draining) begin
          // wait for the last pixel, then let the pipeline settle
          if (turned_px_q.size() == 0) begin
            draining = 1'b0;
            gap_left = SETTLE_CYCLES;
          end
        end else if (feed_plan.size() > 0) begin
          st = feed_plan.pop_front();
          case (st.op)
            OP_WORD: begin
              v_nxt    = 1'b1;
              kind     <= st.kind;
              in_red   <= st.pix[23:16];
              in_green <= st.pix[15:8];
              in_blue  <= st.pix[7:0];
              gap_left = st.gap;
            end
            OP_CFG: begin
              wr_nxt    = 1'b1;
              cfg_index <= st.index;
              cfg_data  <= st.data;
            end
            default: draining = 1'b1;
          endcase
        end else begin
          feed_done = 1'b1;
        end
      end
      in_valid  <= v_nxt;
      cfg_write <= wr_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random output stall, field-by-field pixel check
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  logic        stall_on   = 1'b0;

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : pixel_monitor
    turned_px_t want;
    int unsigned pick;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (turned_px_q.size() == 0) begin
          errors++;
          $display("%0t ns: pixel with none expected, expected nothing, got %0h%0h%0h last %0b",
                   $time, out_red, out_green, out_blue, last_pixel);
        end else begin
          want = turned_px_q.pop_front();
          check_field("out_red", 32'(want.red), 32'(out_red));
          check_field("out_green", 32'(want.green), 32'(out_green));
          check_field("out_blue", 32'(want.blue), 32'(out_blue));
          check_field("last_pixel", 32'(want.last), 32'(last_pixel));
          pixels_seen++;
        end
      end
      // advance the stall pattern: short runs, a few long stalls, quiet stretches
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          stall_on   = 1'b0;
          stall_left = $urandom_range(0, 6);
        end else if (pick < 80) begin
          stall_on   = 1'b1;
          stall_left = $urandom_range(0, 2);
        end else if (pick < 95) begin
          stall_on   = 1'b1;
          stall_left = $urandom_range(5, 30);
        end else begin
          stall_on   = 1'b0;
          stall_left = $urandom_range(100, 300);
        end
      end
      out_stall <= stall_on;
    end
  end

  // ---------------------------------------------------------------------
  // End of run
  // ---------------------------------------------------------------------
  initial begin : finish_run
    while (!(feed_done && turned_px_q.size() == 0)) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Run took %0d words (%0d dropped for the phase), checked %0d turned pixels.",
             words_taken, words_dropped, pixels_seen);
    $display("Frames per turn setting 0/1/2/3: %0d/%0d/%0d/%0d, mismatches: %0d",
             turn_frames[0], turn_frames[1], turn_frames[2], turn_frames[3], errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timeout: %0d pixels still outstanding, %0d steps unsent",
             turned_px_q.size(), feed_plan.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### frame_quarter_turn_rotator_unit.f
sv/frot_pkg.sv
sv/frot_frame_mem.sv
sv/frot_seq.sv
sv/frame_quarter_turn_rotator_unit.sv
verif/tb.sv
